// ===== src/scm_pkg.sv =====
// Shared constants, coefficient tables and types for the sine/cosine pipeline.
package scm_pkg;

  localparam int ANGLE_FRAC_BITS  = 24;
  localparam int RESULT_FRAC_BITS = 30;
  localparam int WORK_FRAC        = 30;
  localparam int RED_FRAC         = 40;

  localparam int ANGLE_W = 32;
  localparam int RES_W   = 32;
  localparam int INV_W   = 30;
  localparam int Y40_W   = 44;
  localparam int Y_W     = 32;
  localparam int Y2_W    = 33;
  localparam int P_W     = 33;
  localparam int HORNER  = 5;

  localparam int RED_STAGES  = 6;
  localparam int POLY_STAGES = 2 * HORNER + 4;
  localparam int PIPE_STAGES = RED_STAGES + POLY_STAGES;

  localparam logic [INV_W-1:0]        INV_TWO_PI = 30'h28BE60DC;
  localparam logic signed [Y40_W-1:0] TWO_PI     = 44'sh6487ED5110B;
  localparam logic signed [Y40_W-1:0] PI         = 44'sh3243F6A8886;
  localparam logic signed [Y40_W-1:0] HALF_PI    = 44'sh1921FB54443;

  typedef logic signed [P_W-1:0] coef_t;

  localparam coef_t SIN_K0 = -33'sd26;
  localparam coef_t COS_K0 = -33'sd280;
  localparam coef_t SIN_ADD [0:HORNER-1] = '{
    33'sd2956, -33'sd213040, 33'sd8947846, -33'sd178956974, 33'sd1073741824
  };
  localparam coef_t COS_ADD [0:HORNER-1] = '{
    33'sd26586, -33'sd1491253, 33'sd44739212, -33'sd536870912, 33'sd1073741824
  };

  typedef struct packed {
    logic signed [Y_W-1:0] y;
    logic                  flip;
  } red_out_t;

endpackage

// ===== src/sin_cos_minimax_top.sv =====
// Top level of the fixed-point sine/cosine pipeline with valid/stall flow control.
//
// Takes one Q8.24 angle per beat and returns its sine and cosine as Q2.30,
// saturated to plus or minus one. The datapath is a 20-stage pipeline: six
// stages of range reduction and fold, two stages of squaring and rounding,
// five Horner steps, each step one multiplier stage and one round-and-add
// stage, then one stage for the final sine multiply and one for output
// rounding. A new angle can enter in every cycle while the output is not
// stalled. Each stage holds its own valid bit, so a stalled output only
// stops the stages that are full and empty stages behind it keep filling.
module sin_cos_minimax_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [scm_pkg::ANGLE_W-1:0] in_angle,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [scm_pkg::RES_W-1:0]   out_sine_value,
  output logic signed [scm_pkg::RES_W-1:0]   out_cosine_value
);
  import scm_pkg::*;

  logic [PIPE_STAGES-1:0] v_r;
  logic [PIPE_STAGES-1:0] v_nxt;
  logic [PIPE_STAGES-1:0] rdy;
  red_out_t               red;

  assign rdy[PIPE_STAGES-1] = !v_r[PIPE_STAGES-1] || !out_stall;
  for (genvar i = 0; i < PIPE_STAGES - 1; i++) begin : g_rdy
    assign rdy[i] = !v_r[i] || rdy[i+1];
  end

  assign v_nxt[0] = rdy[0] ? in_valid : v_r[0];
  for (genvar i = 1; i < PIPE_STAGES; i++) begin : g_vld
    assign v_nxt[i] = rdy[i] ? v_r[i-1] : v_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  scm_reduce u_reduce (
    .clk   (clk),
    .ld    (rdy[RED_STAGES-1:0]),
    .angle (in_angle),
    .red   (red)
  );

  scm_poly u_poly (
    .clk          (clk),
    .ld           (rdy[PIPE_STAGES-1:RED_STAGES]),
    .red          (red),
    .sine_value   (out_sine_value),
    .cosine_value (out_cosine_value)
  );

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[PIPE_STAGES-1];

endmodule

// ===== src/scm_reduce.sv =====
// Range reduction to [-pi,pi] and fold to [-pi/2,pi/2], six register stages.
module scm_reduce (
  input  logic                                 clk,
  input  logic [scm_pkg::RED_STAGES-1:0]       ld,
  input  logic signed [scm_pkg::ANGLE_W-1:0]   angle,
  output scm_pkg::red_out_t                    red
);
  import scm_pkg::*;

  localparam int PROD_W = ANGLE_W + INV_W;
  localparam int Q_SH   = ANGLE_FRAC_BITS + 32;
  localparam int Q_W    = ANGLE_W + 1 - ANGLE_FRAC_BITS;
  localparam int SCL    = RED_FRAC - ANGLE_FRAC_BITS;
  localparam int D_W    = Y40_W + Q_W;
  localparam int YSH    = RED_FRAC - WORK_FRAC;
  localparam logic [PROD_W-1:0] Q_HALF = PROD_W'(1) << (Q_SH - 1);
  localparam logic [Y40_W-1:0]  Y_HALF = Y40_W'(1) << (YSH - 1);

  logic signed [ANGLE_W-1:0] a0_r, a1_r, a2_r;
  logic [ANGLE_W-1:0]        mag0_r;
  logic [PROD_W-1:0]         prod1_r;
  logic signed [Q_W-1:0]     q2_r;
  logic signed [Y40_W-1:0]   y40_3_r, y40_4_r;
  logic                      flip4_r, flip5_r;
  logic signed [Y_W-1:0]     y5_r;

  logic [ANGLE_W-1:0]      mag_nxt;
  logic [PROD_W-1:0]       qsum;
  logic signed [Q_W-1:0]   qm_ext, q_nxt;
  logic signed [D_W-1:0]   diff;
  logic signed [Y40_W-1:0] y40_nxt;
  logic                    flip_nxt;
  logic [Y40_W-1:0]        yt;

  always_comb begin
    mag_nxt = angle[ANGLE_W-1] ? (~angle + ANGLE_W'(1)) : angle;
    qsum    = prod1_r + Q_HALF;
    qm_ext  = Q_W'(qsum[PROD_W-1:Q_SH]);
    q_nxt   = a1_r[ANGLE_W-1] ? -qm_ext : qm_ext;
    diff    = (D_W'(a2_r) <<< SCL) - D_W'(q2_r) * D_W'(TWO_PI);
    if (y40_3_r > HALF_PI) begin
      y40_nxt  = PI - y40_3_r;
      flip_nxt = 1'b1;
    end else if (y40_3_r < -HALF_PI) begin
      y40_nxt  = -PI - y40_3_r;
      flip_nxt = 1'b1;
    end else begin
      y40_nxt  = y40_3_r;
      flip_nxt = 1'b0;
    end
    yt = y40_4_r + Y_HALF - Y40_W'(y40_4_r[Y40_W-1]);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      a0_r   <= angle;
      mag0_r <= mag_nxt;
    end
    if (ld[1]) begin
      a1_r    <= a0_r;
      prod1_r <= PROD_W'(mag0_r) * PROD_W'(INV_TWO_PI);
    end
    if (ld[2]) begin
      a2_r <= a1_r;
      q2_r <= q_nxt;
    end
    if (ld[3]) begin
      y40_3_r <= diff[Y40_W-1:0];
    end
    if (ld[4]) begin
      y40_4_r <= y40_nxt;
      flip4_r <= flip_nxt;
    end
    if (ld[5]) begin
      y5_r    <= yt[YSH+Y_W-1:YSH];
      flip5_r <= flip4_r;
    end
  end

  assign red.y    = y5_r;
  assign red.flip = flip5_r;

endmodule

// ===== src/scm_poly.sv =====
// Horner evaluation of the sine and cosine polynomials and output rounding.
module scm_poly (
  input  logic                               clk,
  input  logic [scm_pkg::POLY_STAGES-1:0]    ld,
  input  scm_pkg::red_out_t                  red,
  output logic signed [scm_pkg::RES_W-1:0]   sine_value,
  output logic signed [scm_pkg::RES_W-1:0]   cosine_value
);
  import scm_pkg::*;

  localparam int YY_W = 2 * Y_W;
  localparam int MW   = P_W + Y2_W;
  localparam int SW   = P_W + Y_W;
  localparam int SH   = WORK_FRAC - RESULT_FRAC_BITS;
  localparam int RW   = P_W + 1 - SH;
  localparam int MUL_S = 2 * HORNER + 2;
  localparam int OUT_S = 2 * HORNER + 3;
  localparam logic signed [RW-1:0] ONE_R = RW'(1) << RESULT_FRAC_BITS;

  function automatic logic signed [RES_W-1:0] to_res(input logic signed [P_W-1:0] v);
    logic [P_W:0]          t;
    logic signed [RW-1:0]  r;
    t = {v[P_W-1], v};
    if (SH != 0) begin
      t = t + ((P_W+1)'(1) << (SH - 1)) - (P_W+1)'(v[P_W-1]);
    end
    r = $signed(t[P_W:SH]);
    if (r > ONE_R) begin
      r = ONE_R;
    end else if (r < -ONE_R) begin
      r = -ONE_R;
    end
    return RES_W'(r);
  endfunction

  logic signed [YY_W-1:0] yy_r;
  logic signed [Y_W-1:0]  y_r  [0:MUL_S-1];
  logic                   f_r  [0:MUL_S];
  logic signed [Y2_W-1:0] y2_r [1:2*HORNER-1];
  logic signed [MW-1:0]   ms_r [0:HORNER-1];
  logic signed [MW-1:0]   mc_r [0:HORNER-1];
  logic signed [P_W-1:0]  as_r [0:HORNER-1];
  logic signed [P_W-1:0]  ac_r [0:HORNER-1];
  logic signed [SW-1:0]   sp_r;
  logic signed [P_W-1:0]  pc_r;
  logic signed [RES_W-1:0] sine_r, cosine_r;

  logic [YY_W-1:0]       yyt;
  logic [SW-1:0]         spt;
  logic signed [P_W-1:0] ps_fin, pc_fin;

  always_comb begin
    yyt    = yy_r + (YY_W'(1) << (WORK_FRAC - 1)) - YY_W'(yy_r[YY_W-1]);
    spt    = sp_r + (SW'(1) << (WORK_FRAC - 1)) - SW'(sp_r[SW-1]);
    ps_fin = spt[WORK_FRAC+P_W-1:WORK_FRAC];
    pc_fin = f_r[MUL_S] ? -pc_r : pc_r;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      yy_r   <= red.y * red.y;
      y_r[0] <= red.y;
      f_r[0] <= red.flip;
    end
    if (ld[1]) begin
      y2_r[1] <= yyt[WORK_FRAC+Y2_W-1:WORK_FRAC];
    end
    if (ld[MUL_S]) begin
      sp_r <= SW'(as_r[HORNER-1]) * SW'(y_r[MUL_S-1]);
      pc_r <= ac_r[HORNER-1];
    end
    if (ld[OUT_S]) begin
      sine_r   <= to_res(ps_fin);
      cosine_r <= to_res(pc_fin);
    end
  end

  for (genvar k = 1; k < MUL_S; k++) begin : g_carry
    always_ff @(posedge clk) begin
      if (ld[k]) begin
        y_r[k] <= y_r[k-1];
      end
    end
  end

  for (genvar k = 1; k <= MUL_S; k++) begin : g_flip
    always_ff @(posedge clk) begin
      if (ld[k]) begin
        f_r[k] <= f_r[k-1];
      end
    end
  end

  for (genvar k = 2; k < 2 * HORNER; k++) begin : g_y2
    always_ff @(posedge clk) begin
      if (ld[k]) begin
        y2_r[k] <= y2_r[k-1];
      end
    end
  end

  for (genvar j = 0; j < HORNER; j++) begin : g_horner
    logic signed [P_W-1:0] ps_in, pc_in;
    logic [MW-1:0]         st, ct;
    if (j == 0) begin : g_first
      assign ps_in = SIN_K0;
      assign pc_in = COS_K0;
    end else begin : g_next
      assign ps_in = as_r[j-1];
      assign pc_in = ac_r[j-1];
    end
    assign st = ms_r[j] + (MW'(1) << (WORK_FRAC - 1)) - MW'(ms_r[j][MW-1]);
    assign ct = mc_r[j] + (MW'(1) << (WORK_FRAC - 1)) - MW'(mc_r[j][MW-1]);
    always_ff @(posedge clk) begin
      if (ld[2+2*j]) begin
        ms_r[j] <= MW'(ps_in) * MW'(y2_r[1+2*j]);
        mc_r[j] <= MW'(pc_in) * MW'(y2_r[1+2*j]);
      end
      if (ld[3+2*j]) begin
        as_r[j] <= $signed(st[WORK_FRAC+P_W-1:WORK_FRAC]) + SIN_ADD[j];
        ac_r[j] <= $signed(ct[WORK_FRAC+P_W-1:WORK_FRAC]) + COS_ADD[j];
      end
    end
  end

  assign sine_value   = sine_r;
  assign cosine_value = cosine_r;

endmodule

// ===== verif/sin_cos_minimax_checker.sv =====
// Checker for the sine/cosine pipeline: predicts each angle beat and compares result beats.
module sin_cos_minimax_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [scm_pkg::ANGLE_W-1:0] in_angle,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [scm_pkg::RES_W-1:0]   out_sine_value,
  input  logic signed [scm_pkg::RES_W-1:0]   out_cosine_value,
  output int                                 mismatch_count,
  output int                                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANG_FRAC  = 24;
  localparam int RES_FRAC  = 30;
  localparam int POLY_FRAC = 30;
  localparam int FOLD_FRAC = 40;

  localparam longint unsigned RECIP_TWO_PI = 64'h28BE60DC;
  localparam longint TWO_PI_F40  = 64'sh6487ED5110B;
  localparam longint PI_F40      = 64'sh3243F6A8886;
  localparam longint HALF_PI_F40 = 64'sh1921FB54443;

  typedef struct packed {
    logic signed [scm_pkg::RES_W-1:0] sine;
    logic signed [scm_pkg::RES_W-1:0] cosine;
  } sincos_t;

  sincos_t sincos_due[$];

  function automatic longint round_away(longint v, int s);
    longint unsigned m;
    bit neg;
    if (s == 0) return v;
    neg = v < 0;
    m = neg ? -v : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint mul_fix(longint a, longint b);
    return round_away(a * b, POLY_FRAC);
  endfunction

  function automatic longint sine_coef(int i);
    case (i)
      0: return -64'sd26;
      1: return 64'sd2956;
      2: return -64'sd213040;
      3: return 64'sd8947846;
      4: return -64'sd178956974;
      default: return 64'sd1 <<< POLY_FRAC;
    endcase
  endfunction

  function automatic longint cosine_coef(int i);
    case (i)
      0: return -64'sd280;
      1: return 64'sd26586;
      2: return -64'sd1491253;
      3: return 64'sd44739212;
      4: return -(64'sd1 <<< (POLY_FRAC - 1));
      default: return 64'sd1 <<< POLY_FRAC;
    endcase
  endfunction

  function automatic logic signed [scm_pkg::RES_W-1:0] clamp_unit(longint v);
    longint r;
    longint one;
    r = round_away(v, POLY_FRAC - RES_FRAC);
    one = 64'sd1 <<< RES_FRAC;
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[scm_pkg::RES_W-1:0];
  endfunction

  function automatic sincos_t sincos_of(logic signed [scm_pkg::ANGLE_W-1:0] ang);
    longint a;
    longint unsigned mag;
    longint unsigned qm;
    longint q;
    longint y40;
    longint y;
    longint y2;
    longint ps;
    longint pc;
    bit flip;
    sincos_t r;
    a = ang;
    mag = (a < 0) ? -a : a;
    qm = (mag * RECIP_TWO_PI + (64'd1 << (ANG_FRAC + 31))) >> (ANG_FRAC + 32);
    q = (a < 0) ? -longint'(qm) : longint'(qm);
    y40 = a * (64'sd1 <<< (FOLD_FRAC - ANG_FRAC)) - q * TWO_PI_F40;
    flip = 1'b0;
    if (y40 > HALF_PI_F40) begin
      y40 = PI_F40 - y40;
      flip = 1'b1;
    end else if (y40 < -HALF_PI_F40) begin
      y40 = -PI_F40 - y40;
      flip = 1'b1;
    end
    y = round_away(y40, FOLD_FRAC - POLY_FRAC);
    y2 = mul_fix(y, y);
    ps = sine_coef(0);
    pc = cosine_coef(0);
    for (int i = 1; i < 6; i++) begin
      ps = mul_fix(ps, y2) + sine_coef(i);
      pc = mul_fix(pc, y2) + cosine_coef(i);
    end
    ps = mul_fix(ps, y);
    if (flip) pc = -pc;
    r.sine = clamp_unit(ps);
    r.cosine = clamp_unit(pc);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    sincos_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) sincos_due.push_back(sincos_of(in_angle));
      if (out_valid && !out_stall) begin
        if (sincos_due.size() == 0) begin
          $error("result beat with none expected: sine_value %0d cosine_value %0d",
                 out_sine_value, out_cosine_value);
          mismatch_count++;
        end else begin
          want = sincos_due.pop_front();
          if (out_sine_value !== want.sine) begin
            $error("sine_value: expected %0d, actual %0d", want.sine, out_sine_value);
            mismatch_count++;
          end
          if (out_cosine_value !== want.cosine) begin
            $error("cosine_value: expected %0d, actual %0d", want.cosine, out_cosine_value);
            mismatch_count++;
          end
        end
      end
    end
    outstanding <= sincos_due.size();
  end

endmodule

// ===== verif/sin_cos_minimax_top_test.sv =====
// Testbench top for the sine/cosine pipeline: clock, reset, angle and stall stimulus, verdict.
module sin_cos_minimax_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 40;
  localparam longint HALF_PI_Q24 = 26353589;
  localparam longint PI_Q24      = 52707179;

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  logic signed [scm_pkg::ANGLE_W-1:0] in_angle;
  logic                               out_valid;
  logic                               out_stall;
  logic signed [scm_pkg::RES_W-1:0]   out_sine_value;
  logic signed [scm_pkg::RES_W-1:0]   out_cosine_value;

  int mismatch_count;
  int outstanding;
  int cycles;
  int send_gap_max;
  int recv_gap_max;
  bit hold_request;

  sin_cos_minimax_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_angle         (in_angle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sine_value   (out_sine_value),
    .out_cosine_value (out_cosine_value)
  );

  sin_cos_minimax_checker sincos_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_angle         (in_angle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sine_value   (out_sine_value),
    .out_cosine_value (out_cosine_value),
    .mismatch_count   (mismatch_count),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sin_cos_minimax_top: mismatch");
      $finish;
    end
  end

  function automatic logic signed [31:0] near_multiple(longint step, int k);
    return 32'(longint'(k) * step + longint'($urandom_range(0, 64)) - 32);
  endfunction

  function automatic logic signed [31:0] random_angle();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) return $urandom;
    if (pick <= 7) return near_multiple(HALF_PI_Q24, int'($urandom_range(0, 162)) - 81);
    if (pick == 8) return 32'(int'($urandom_range(0, 2097152)) - 1048576);
    return near_multiple(PI_Q24, 2 * (int'($urandom_range(0, 39)) - 20) + 1);
  endfunction

  task automatic offer_angle(input logic signed [31:0] ang);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle <= ang;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic offer_random(input int n);
    repeat (n) offer_angle(random_angle());
  endtask

  // receiver: stall per beat, long hold on request
  initial begin
    int w;
    bit hold_done;
    out_stall <= 1'b0;
    hold_done = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request && !hold_done) begin
        w = LONG_HOLD;
        hold_done = 1'b1;
      end else begin
        w = $urandom_range(0, recv_gap_max);
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic signed [31:0] corner_angles[$];
    send_gap_max = 6;
    recv_gap_max = 6;
    hold_request = 1'b0;
    in_valid <= 1'b0;
    in_angle <= '0;
    rst_n <= 1'b0;
    corner_angles = '{
      32'sh00000000, 32'sh00000001, 32'shFFFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
      32'sh80000001, 32'sh7FFFFFFE,
      32'sd26353588, 32'sd26353589, 32'sd26353590,
      -32'sd26353588, -32'sd26353589, -32'sd26353590,
      32'sd52707178, 32'sd52707179, -32'sd52707178, -32'sd52707179,
      32'sd158121535, 32'sd158121536, -32'sd158121535, -32'sd158121536,
      32'sd105414357, -32'sd105414357, 32'sh55555555, 32'shAAAAAAAA
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_angles[i]) offer_angle(corner_angles[i]);
    offer_random(300);

    send_gap_max = 0;
    recv_gap_max = 0;
    offer_random(200);

    send_gap_max = 6;
    recv_gap_max = 6;
    hold_request = 1'b1;
    offer_random(100);
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    offer_random(500);
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("sin_cos_minimax_top: match");
    end else begin
      $display("sin_cos_minimax_top: mismatch");
    end
    $finish;
  end

endmodule
